>>> rtl/linear_blend_skinning_assert.svh
// ----------------------------------------------------------------------------
// linear blend skinning assertion macros
// clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef LINEAR_BLEND_SKINNING_ASSERT_SVH
`define LINEAR_BLEND_SKINNING_ASSERT_SVH

// consequent checked in the same cycle
`define LBS_ASSERT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define LBS_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg
// operation codes, widths and saturating fixed point helpers for skinning
// ----------------------------------------------------------------------------
package lbs_pkg;

  localparam logic [1:0] OP_WORLD     = 2'd0;
  localparam logic [1:0] OP_INV_BIND  = 2'd1;
  localparam logic [1:0] OP_INFLUENCE = 2'd2;

  localparam int WORDS_PER_JOINT = 12;
  localparam int SQRT_STEPS      = 32;
  localparam int QUO_BITS        = 17;

  localparam logic signed [63:0] ACC64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] ACC64_MIN = {1'b1, {63{1'b0}}};
  localparam logic signed [39:0] ACC40_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] ACC40_MIN = {1'b1, {39{1'b0}}};
  localparam logic signed [31:0] Q32_MAX   = {1'b0, {31{1'b1}}};
  localparam logic signed [31:0] Q32_MIN   = {1'b1, {31{1'b0}}};

  // word index of a column/row pair inside one 3x4 matrix
  function automatic logic [3:0] mat_idx(input logic [1:0] col, input logic [1:0] row);
    return {1'b0, col, 1'b0} + {2'b0, col} + {2'b0, row};
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [65:0] b);
    logic [66:0] s;
    logic signed [63:0] res;
    s = {{3{a[63]}}, a} + {b[65], b};
    if (s[66:63] == {4{s[66]}}) res = s[63:0];
    else if (s[66])             res = ACC64_MIN;
    else                        res = ACC64_MAX;
    return res;
  endfunction

  function automatic logic signed [39:0] sat_add40(input logic signed [39:0] a,
                                                   input logic signed [65:0] b);
    logic [66:0] s;
    logic signed [39:0] res;
    s = {{27{a[39]}}, a} + {b[65], b};
    if (s[66:39] == {28{s[66]}}) res = s[39:0];
    else if (s[66])              res = ACC40_MIN;
    else                         res = ACC40_MAX;
    return res;
  endfunction

  // round half up to q16.16 and clamp to 32 bits
  function automatic logic signed [31:0] round_q16_sat32(input logic signed [63:0] x);
    logic signed [63:0] t;
    logic [47:0] h;
    logic signed [31:0] res;
    t = sat_add64(x, 66'sd32768);
    h = t[63:16];
    if (h[47:31] == {17{h[47]}}) res = h[31:0];
    else if (h[47])              res = Q32_MIN;
    else                         res = Q32_MAX;
    return res;
  endfunction

endpackage

>>> rtl/linear_blend_skinning.sv
// ----------------------------------------------------------------------------
// linear_blend_skinning
// matrix tables, per joint skinning transform and blended normal on one
// shared 33x33 multiplier under a sequencer
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o | operation .. last_influence
//  out     | output    | out_valid_o/out_ready_i | out_pos_* , out_nrm_*
//
//  table writes complete without leaving idle, so ready stays high
//  an influence runs through 12 matrix entries, two transforms, then a unit
//  vector pass (shifts, a 32 step square root, three divides) and the
//  weights
//  the last influence adds a second unit vector pass and the output step
//  reset clears the accumulators; a waiting result stalls only the final step
// ----------------------------------------------------------------------------
module linear_blend_skinning #(
  parameter int JOINTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic [5:0]         joint_index_i,
  input  logic [3:0]         word_index_i,
  input  logic signed [31:0] word_value_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [17:0] nrm_x_i,
  input  logic signed [17:0] nrm_y_i,
  input  logic signed [17:0] nrm_z_i,
  input  logic [16:0]        influence_weight_i,
  input  logic               last_influence_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_pos_x_o,
  output logic signed [31:0] out_pos_y_o,
  output logic signed [31:0] out_pos_z_o,
  output logic signed [17:0] out_nrm_x_o,
  output logic signed [17:0] out_nrm_y_o,
  output logic signed [17:0] out_nrm_z_o
);
  import lbs_pkg::*;

  localparam int Depth = JOINTS * WORDS_PER_JOINT;
  localparam int AW    = $clog2(Depth);
  localparam logic [8:0] JointLimit = 9'(JOINTS);

  typedef enum logic [4:0] {
    ST_IDLE, ST_M_INIT, ST_M_INITW, ST_M_RD, ST_M_MUL, ST_M_ACC, ST_M_STORE,
    ST_T_INIT, ST_T_MUL, ST_T_ACC, ST_T_STORE,
    ST_U_LOAD, ST_U_SHR, ST_U_SHL, ST_U_SQ, ST_U_SQA, ST_U_SQI, ST_U_SQRT,
    ST_U_DINIT, ST_U_DIV, ST_U_DEND,
    ST_W_MUL, ST_W_ACC, ST_F_OUT
  } state_e;

  state_e state_q;
  logic [1:0] c_q, r_q, k_q, i_q;
  logic [4:0] iter_q;
  logic pass_q, wsel_q, final_q;

  // captured influence
  logic [11:0] base_q;
  logic jok_q, last_q;
  logic signed [31:0] pos_q [3];
  logic signed [17:0] nrm_q [3];
  logic [16:0] wgt_q;

  // datapath
  logic signed [63:0] acc_q;
  logic signed [65:0] prod_q, prod_d;
  logic signed [32:0] mul_a, mul_b;
  logic signed [31:0] m_q  [12];
  logic signed [31:0] tv_q [3];
  logic signed [63:0] tn_q [3];
  logic [51:0] mag_q [3];
  logic sgn_q [3];
  logic [63:0] sx_q, sr_q, sb_q;
  logic [47:0] rem_q, dsh_q;
  logic [QUO_BITS-1:0] quo_q;
  logic signed [17:0] un_q [3];
  logic signed [63:0] pacc_q [3];
  logic signed [39:0] nacc_q [3];

  logic out_valid_q;
  logic signed [31:0] out_pos_q [3];
  logic signed [17:0] out_nrm_q [3];

  // ---------------------------------------------------------------- tables
  logic signed [31:0] wm_mem [Depth];
  logic signed [31:0] ib_mem [Depth];
  logic signed [31:0] wm_rd_q, ib_rd_q, wm_val, ib_val;
  logic [AW-1:0] wr_addr, wm_raddr, ib_raddr;
  logic [11:0] in_base;
  logic [3:0] widx, bidx;
  logic in_accept, joint_ok, word_ok, wm_we, ib_we;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign joint_ok   = {3'b0, joint_index_i} < JointLimit;
  assign word_ok    = word_index_i < 4'(WORDS_PER_JOINT);
  assign in_base    = {3'b0, joint_index_i, 3'b0} + {4'b0, joint_index_i, 2'b0};
  assign wr_addr    = AW'(in_base + {8'b0, word_index_i});
  assign wm_we      = in_accept && operation_i == OP_WORLD && joint_ok && word_ok;
  assign ib_we      = in_accept && operation_i == OP_INV_BIND && joint_ok && word_ok;

  assign widx     = (state_q == ST_M_INIT) ? mat_idx(2'd3, r_q) : mat_idx(k_q, r_q);
  assign bidx     = mat_idx(c_q, k_q);
  assign wm_raddr = AW'(base_q + {8'b0, widx});
  assign ib_raddr = AW'(base_q + {8'b0, bidx});

  always_ff @(posedge clk_i) begin
    if (wm_we) wm_mem[wr_addr] <= word_value_i;
    wm_rd_q <= wm_mem[wm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ib_we) ib_mem[wr_addr] <= word_value_i;
    ib_rd_q <= ib_mem[ib_raddr];
  end

  // joints past the table use an all-zero matrix
  assign wm_val = jok_q ? wm_rd_q : '0;
  assign ib_val = jok_q ? ib_rd_q : '0;

  // ------------------------------------------------------ shared multiplier
  logic signed [31:0] m_cur, m_trans;
  assign m_cur   = m_q[mat_idx(c_q, r_q)];
  assign m_trans = m_q[mat_idx(2'd3, r_q)];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_M_MUL: begin
        mul_a = {wm_val[31], wm_val};
        mul_b = {ib_val[31], ib_val};
      end
      ST_T_MUL: begin
        mul_a = {m_cur[31], m_cur};
        mul_b = pass_q ? {{15{nrm_q[c_q][17]}}, nrm_q[c_q]}
                       : {pos_q[c_q][31], pos_q[c_q]};
      end
      ST_U_SQ: begin
        mul_a = {3'b0, mag_q[i_q][29:0]};
        mul_b = {3'b0, mag_q[i_q][29:0]};
      end
      ST_W_MUL: begin
        mul_a = wsel_q ? {{15{un_q[r_q][17]}}, un_q[r_q]} : {tv_q[r_q][31], tv_q[r_q]};
        mul_b = {16'b0, wgt_q};
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // ------------------------------------------------ unit vector support
  logic signed [63:0] src [3];
  logic [63:0] src_abs [3];
  logic src_zero, any_hi, any_29;
  logic [63:0] sq_t;
  logic sq_ge, div_ge;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      src[j]     = final_q ? {{24{nacc_q[j][39]}}, nacc_q[j]} : tn_q[j];
      src_abs[j] = src[j][63] ? (64'd0 - src[j]) : src[j];
    end
  end

  assign src_zero = (src[0] == '0) && (src[1] == '0) && (src[2] == '0);
  assign any_hi   = (|mag_q[0][51:30]) || (|mag_q[1][51:30]) || (|mag_q[2][51:30]);
  assign any_29   = (|mag_q[0][51:29]) || (|mag_q[1][51:29]) || (|mag_q[2][51:29]);
  assign sq_t     = sr_q + sb_q;
  assign sq_ge    = sx_q >= sq_t;
  assign div_ge   = rem_q >= dsh_q;

  // ---------------------------------------------------------- datapath regs
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && operation_i == OP_INFLUENCE) begin
          base_q   <= in_base;
          jok_q    <= joint_ok;
          last_q   <= last_influence_i;
          wgt_q    <= influence_weight_i;
          pos_q[0] <= pos_x_i;
          pos_q[1] <= pos_y_i;
          pos_q[2] <= pos_z_i;
          nrm_q[0] <= nrm_x_i;
          nrm_q[1] <= nrm_y_i;
          nrm_q[2] <= nrm_z_i;
        end
      end
      ST_M_INITW: acc_q <= (c_q == 2'd3) ? {{16{wm_val[31]}}, wm_val, 16'b0} : '0;
      ST_M_ACC, ST_T_ACC, ST_U_SQA: acc_q <= sat_add64(acc_q, prod_q);
      ST_M_STORE: m_q[mat_idx(c_q, r_q)] <= round_q16_sat32(acc_q);
      ST_T_INIT: acc_q <= pass_q ? '0 : {{16{m_trans[31]}}, m_trans, 16'b0};
      ST_T_STORE: begin
        if (pass_q) tn_q[r_q] <= acc_q;
        else        tv_q[r_q] <= round_q16_sat32(acc_q);
      end
      ST_U_LOAD: begin
        acc_q <= '0;
        for (int j = 0; j < 3; j++) begin
          mag_q[j] <= src_abs[j][51:0];
          sgn_q[j] <= src[j][63];
          if (src_zero) un_q[j] <= '0;
        end
      end
      ST_U_SHR: begin
        if (any_hi) begin
          for (int j = 0; j < 3; j++) mag_q[j] <= mag_q[j] >> 1;
        end
      end
      ST_U_SHL: begin
        if (!any_29) begin
          for (int j = 0; j < 3; j++) mag_q[j] <= mag_q[j] << 1;
        end
      end
      ST_U_SQI: begin
        sx_q <= acc_q;
        sr_q <= '0;
        sb_q <= {2'b01, 62'b0};
      end
      ST_U_SQRT: begin
        if (sq_ge) begin
          sx_q <= sx_q - sq_t;
          sr_q <= (sr_q >> 1) + sb_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sb_q <= sb_q >> 2;
      end
      ST_U_DINIT: begin
        // numerator carries half the length for round half up
        rem_q <= {2'b0, mag_q[i_q][29:0], 16'b0} + {17'b0, sr_q[31:1]};
        dsh_q <= {sr_q[31:0], 16'b0};
        quo_q <= '0;
      end
      ST_U_DIV: begin
        if (div_ge) rem_q <= rem_q - dsh_q;
        quo_q <= {quo_q[QUO_BITS-2:0], div_ge};
        dsh_q <= dsh_q >> 1;
      end
      ST_U_DEND: un_q[i_q] <= sgn_q[i_q] ? (18'd0 - {1'b0, quo_q}) : {1'b0, quo_q};
      default: ;
    endcase
  end

  // ------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      c_q         <= '0;
      r_q         <= '0;
      k_q         <= '0;
      i_q         <= '0;
      iter_q      <= '0;
      pass_q      <= 1'b0;
      wsel_q      <= 1'b0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < 3; j++) begin
        pacc_q[j]    <= '0;
        nacc_q[j]    <= '0;
        out_pos_q[j] <= '0;
        out_nrm_q[j] <= '0;
      end
    end else begin
      if (out_valid_q && out_ready_i && state_q != ST_F_OUT) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept && operation_i == OP_INFLUENCE) begin
            c_q     <= '0;
            r_q     <= '0;
            k_q     <= '0;
            state_q <= ST_M_INIT;
          end
        end
        ST_M_INIT: state_q <= ST_M_INITW;
        ST_M_INITW: begin
          k_q     <= '0;
          state_q <= ST_M_RD;
        end
        ST_M_RD:  state_q <= ST_M_MUL;
        ST_M_MUL: state_q <= ST_M_ACC;
        ST_M_ACC: begin
          if (k_q == 2'd2) begin
            state_q <= ST_M_STORE;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= ST_M_RD;
          end
        end
        ST_M_STORE: begin
          if (r_q == 2'd2) begin
            r_q <= '0;
            if (c_q == 2'd3) begin
              pass_q  <= 1'b0;
              state_q <= ST_T_INIT;
            end else begin
              c_q     <= c_q + 2'd1;
              state_q <= ST_M_INIT;
            end
          end else begin
            r_q     <= r_q + 2'd1;
            state_q <= ST_M_INIT;
          end
        end
        ST_T_INIT: begin
          c_q     <= '0;
          state_q <= ST_T_MUL;
        end
        ST_T_MUL: state_q <= ST_T_ACC;
        ST_T_ACC: begin
          if (c_q == 2'd2) begin
            state_q <= ST_T_STORE;
          end else begin
            c_q     <= c_q + 2'd1;
            state_q <= ST_T_MUL;
          end
        end
        ST_T_STORE: begin
          if (r_q == 2'd2) begin
            r_q <= '0;
            if (pass_q) begin
              final_q <= 1'b0;
              state_q <= ST_U_LOAD;
            end else begin
              pass_q  <= 1'b1;
              state_q <= ST_T_INIT;
            end
          end else begin
            r_q     <= r_q + 2'd1;
            state_q <= ST_T_INIT;
          end
        end
        ST_U_LOAD: begin
          i_q <= '0;
          if (src_zero) begin
            r_q     <= '0;
            wsel_q  <= 1'b0;
            state_q <= final_q ? ST_F_OUT : ST_W_MUL;
          end else begin
            state_q <= ST_U_SHR;
          end
        end
        ST_U_SHR: if (!any_hi) state_q <= ST_U_SHL;
        ST_U_SHL: if (any_29) state_q <= ST_U_SQ;
        ST_U_SQ:  state_q <= ST_U_SQA;
        ST_U_SQA: begin
          if (i_q == 2'd2) begin
            i_q     <= '0;
            state_q <= ST_U_SQI;
          end else begin
            i_q     <= i_q + 2'd1;
            state_q <= ST_U_SQ;
          end
        end
        ST_U_SQI: begin
          iter_q  <= '0;
          state_q <= ST_U_SQRT;
        end
        ST_U_SQRT: begin
          if (iter_q == 5'(SQRT_STEPS - 1)) state_q <= ST_U_DINIT;
          else iter_q <= iter_q + 5'd1;
        end
        ST_U_DINIT: begin
          iter_q  <= '0;
          state_q <= ST_U_DIV;
        end
        ST_U_DIV: begin
          if (iter_q == 5'(QUO_BITS - 1)) state_q <= ST_U_DEND;
          else iter_q <= iter_q + 5'd1;
        end
        ST_U_DEND: begin
          if (i_q == 2'd2) begin
            r_q     <= '0;
            wsel_q  <= 1'b0;
            state_q <= final_q ? ST_F_OUT : ST_W_MUL;
          end else begin
            i_q     <= i_q + 2'd1;
            state_q <= ST_U_DINIT;
          end
        end
        ST_W_MUL: state_q <= ST_W_ACC;
        ST_W_ACC: begin
          if (!wsel_q) begin
            pacc_q[r_q] <= sat_add64(pacc_q[r_q], prod_q);
            wsel_q      <= 1'b1;
            state_q     <= ST_W_MUL;
          end else begin
            nacc_q[r_q] <= sat_add40(nacc_q[r_q], prod_q);
            wsel_q      <= 1'b0;
            if (r_q == 2'd2) begin
              r_q <= '0;
              if (last_q) begin
                final_q <= 1'b1;
                state_q <= ST_U_LOAD;
              end else begin
                state_q <= ST_IDLE;
              end
            end else begin
              r_q     <= r_q + 2'd1;
              state_q <= ST_W_MUL;
            end
          end
        end
        ST_F_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            final_q     <= 1'b0;
            for (int j = 0; j < 3; j++) begin
              out_pos_q[j] <= round_q16_sat32(pacc_q[j]);
              out_nrm_q[j] <= un_q[j];
              pacc_q[j]    <= '0;
              nacc_q[j]    <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pos_x_o = out_pos_q[0];
  assign out_pos_y_o = out_pos_q[1];
  assign out_pos_z_o = out_pos_q[2];
  assign out_nrm_x_o = out_nrm_q[0];
  assign out_nrm_y_o = out_nrm_q[1];
  assign out_nrm_z_o = out_nrm_q[2];

endmodule

>>> rtl/lbs_checker.sv
// ----------------------------------------------------------------------------
// lbs_checker
// port level checks on the skinning block, bound to the top level
// ----------------------------------------------------------------------------
`include "linear_blend_skinning_assert.svh"

module lbs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         operation_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] out_pos_x_o,
  input logic signed [17:0] out_nrm_x_o,
  input logic signed [17:0] out_nrm_y_o,
  input logic signed [17:0] out_nrm_z_o
);
  import lbs_pkg::*;

  // an influence request keeps the block busy
  `LBS_ASSERT_NEXT(a_infl_busy, in_valid_i && in_ready_o && operation_i == OP_INFLUENCE, !in_ready_o, "ready after influence request")
  // table writes and unused operations leave the block ready
  `LBS_ASSERT_NEXT(a_load_ready, in_valid_i && in_ready_o && operation_i != OP_INFLUENCE, in_ready_o, "ready dropped after table write")
  // a result only comes out of a busy block
  `LBS_ASSERT(a_result_busy, $rose(out_valid_o), $past(!in_ready_o), "result while idle")
  // unit normal stays within one
  `LBS_ASSERT(a_nrm_range, out_valid_o, ($signed(out_nrm_x_o) <= 18'sd65536) && ($signed(out_nrm_x_o) >= -18'sd65536) && ($signed(out_nrm_y_o) <= 18'sd65536) && ($signed(out_nrm_y_o) >= -18'sd65536) && ($signed(out_nrm_z_o) <= 18'sd65536) && ($signed(out_nrm_z_o) >= -18'sd65536), "normal out of range")
  `LBS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_pos_x_o), "stalled result changed")

endmodule

bind linear_blend_skinning lbs_checker u_lbs_checker (.*);

>>> tb/sv/linear_blend_skinning_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_blend_skinning_test
// loads joint matrices, streams skinning influences with random bursts and
// output stalls, and checks every skinned vertex against a local predictor
// ----------------------------------------------------------------------------
module linear_blend_skinning_test;
  import lbs_pkg::*;

  localparam int NJOINTS      = 64;
  localparam int RANDOM_ITEMS = 1650;
  localparam int DRAIN_CYCLES = 1500;
  localparam int IDLE_LIMIT   = 30000;
  localparam int HOLD_CYCLES  = 4000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         op;
    logic [5:0]         joint;
    logic [3:0]         word;
    logic signed [31:0] value;
    logic signed [31:0] px, py, pz;
    logic signed [17:0] nx, ny, nz;
    logic [16:0]        weight;
    logic               last;
  } skin_req_t;

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic signed [17:0] nx, ny, nz;
  } vertex_t;

  class skin_scoreboard;
    int      world_tbl[NJOINTS*12];
    int      invb_tbl[NJOINTS*12];
    longint  pos_acc[3];
    longint  nrm_acc[3];
    vertex_t vertex_q[$];
    int      errors;

    function new();
      errors = 0;
      foreach (pos_acc[i]) begin
        pos_acc[i] = 0;
        nrm_acc[i] = 0;
      end
    endfunction

    function int pending();
      return vertex_q.size();
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    function longint sat_add(longint a, longint b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return s[63:0];
    endfunction

    function longint round_sat(longint x);
      longint t;
      t = sat_add(x, 32768) >>> 16;
      if (t > 64'sd2147483647) return 64'sd2147483647;
      if (t < -64'sd2147483648) return -64'sd2147483648;
      return t;
    endfunction

    function longint unsigned isqrt(longint unsigned x);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
        if (x >= r + bitv) begin
          x -= r + bitv;
          r = (r >> 1) + bitv;
        end else r >>= 1;
        bitv >>= 2;
      end
      return r;
    endfunction

    function void unit_vec(input longint t[3], output longint u[3]);
      longint unsigned mag[3], mx, sum, len, q;
      mx = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = t[i] < 0 ? 64'd0 - t[i] : t[i];
        if (mag[i] > mx) mx = mag[i];
      end
      if (mx == 0) begin
        u[0] = 0; u[1] = 0; u[2] = 0;
        return;
      end
      while (mx >= (64'd1 << 30)) begin
        for (int i = 0; i < 3; i++) mag[i] >>= 1;
        mx >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
        for (int i = 0; i < 3; i++) mag[i] <<= 1;
        mx <<= 1;
      end
      for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
      len = isqrt(sum);
      for (int i = 0; i < 3; i++) begin
        q = (mag[i] * 65536 + len / 2) / len;
        u[i] = t[i] < 0 ? -longint'(q) : longint'(q);
      end
    endfunction

    function void note_request(skin_req_t r);
      longint w[12], b[12], m[12], p[3], n[3], tv[3], tn[3], un[3], s, sn;
      longint wt, lo40, hi40;
      vertex_t v;
      int base;
      base = r.joint * 12;
      if (r.op == OP_WORLD || r.op == OP_INV_BIND) begin
        if (r.joint < NJOINTS && r.word < WORDS_PER_JOINT) begin
          if (r.op == OP_WORLD) world_tbl[base + r.word] = r.value;
          else invb_tbl[base + r.word] = r.value;
        end
        return;
      end
      if (r.op != OP_INFLUENCE) return;
      for (int k = 0; k < 12; k++) begin
        w[k] = world_tbl[base + k];
        b[k] = invb_tbl[base + k];
      end
      for (int c = 0; c < 4; c++)
        for (int rr = 0; rr < 3; rr++) begin
          s = (c == 3) ? w[9 + rr] * 65536 : 0;
          for (int k = 0; k < 3; k++) s = sat_add(s, w[k*3 + rr] * b[c*3 + k]);
          m[c*3 + rr] = round_sat(s);
        end
      p[0] = r.px; p[1] = r.py; p[2] = r.pz;
      n[0] = r.nx; n[1] = r.ny; n[2] = r.nz;
      for (int rr = 0; rr < 3; rr++) begin
        s = m[9 + rr] * 65536;
        sn = 0;
        for (int c = 0; c < 3; c++) begin
          s = sat_add(s, m[c*3 + rr] * p[c]);
          sn += m[c*3 + rr] * n[c];
        end
        tv[rr] = round_sat(s);
        tn[rr] = sn;
      end
      unit_vec(tn, un);
      wt = r.weight;
      lo40 = ACC40_MIN;
      hi40 = ACC40_MAX;
      for (int rr = 0; rr < 3; rr++) begin
        pos_acc[rr] = sat_add(pos_acc[rr], tv[rr] * wt);
        nrm_acc[rr] = nrm_acc[rr] + un[rr] * wt;
        if (nrm_acc[rr] > hi40) nrm_acc[rr] = hi40;
        if (nrm_acc[rr] < lo40) nrm_acc[rr] = lo40;
      end
      if (!r.last) return;
      unit_vec(nrm_acc, un);
      v.px = 32'(round_sat(pos_acc[0]));
      v.py = 32'(round_sat(pos_acc[1]));
      v.pz = 32'(round_sat(pos_acc[2]));
      v.nx = un[0][17:0];
      v.ny = un[1][17:0];
      v.nz = un[2][17:0];
      vertex_q = {vertex_q, v};
      for (int rr = 0; rr < 3; rr++) begin
        pos_acc[rr] = 0;
        nrm_acc[rr] = 0;
      end
    endfunction

    task check_result(vertex_t got);
      vertex_t want;
      if (vertex_q.size() == 0) begin
        report_mismatch("vertex with none pending, pos_x", got.px, 0);
        return;
      end
      want = vertex_q.pop_front();
      if (got.px !== want.px) report_mismatch("pos_x", got.px, want.px);
      if (got.py !== want.py) report_mismatch("pos_y", got.py, want.py);
      if (got.pz !== want.pz) report_mismatch("pos_z", got.pz, want.pz);
      if (got.nx !== want.nx) report_mismatch("nrm_x", got.nx, want.nx);
      if (got.ny !== want.ny) report_mismatch("nrm_y", got.ny, want.ny);
      if (got.nz !== want.nz) report_mismatch("nrm_z", got.nz, want.nz);
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         operation_i = OP_WORLD;
  logic [5:0]         joint_index_i = '0;
  logic [3:0]         word_index_i = '0;
  logic signed [31:0] word_value_i = '0;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [17:0] nrm_x_i = '0, nrm_y_i = '0, nrm_z_i = '0;
  logic [16:0]        influence_weight_i = '0;
  logic               last_influence_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] out_pos_x_o, out_pos_y_o, out_pos_z_o;
  logic signed [17:0] out_nrm_x_o, out_nrm_y_o, out_nrm_z_o;

  linear_blend_skinning #(.JOINTS(NJOINTS)) dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  skin_scoreboard sb = new();
  logic [23:0] written_mask [NJOINTS];
  bit  drv_valid = 0;
  bit  hold_req = 0;
  int  burst_left = 0;
  int  idle_cycles = 0;

  // request and vertex monitor, plus the watchdog
  always @(posedge clk_i) begin
    skin_req_t r;
    vertex_t   v;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        r.op = operation_i; r.joint = joint_index_i; r.word = word_index_i;
        r.value = word_value_i;
        r.px = pos_x_i; r.py = pos_y_i; r.pz = pos_z_i;
        r.nx = nrm_x_i; r.ny = nrm_y_i; r.nz = nrm_z_i;
        r.weight = influence_weight_i; r.last = last_influence_i;
        sb.note_request(r);
      end
      if (out_valid_o && out_ready_i) begin
        v.px = out_pos_x_o; v.py = out_pos_y_o; v.pz = out_pos_z_o;
        v.nx = out_nrm_x_o; v.ny = out_nrm_y_o; v.nz = out_nrm_z_o;
        sb.check_result(v);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // receiver: stall pattern changes after random spans, one long hold
  initial begin
    int mode, span, hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    mode = 0;
    span = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(50, 400);
      end
      span--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (mode == 0) out_ready_i <= 1'b1;
      else if (mode == 1) out_ready_i <= 1'($urandom_range(0, 1));
      else out_ready_i <= ($urandom_range(0, 7) == 0);
    end
  end

  task automatic send(skin_req_t r);
    int gap;
    operation_i <= r.op; joint_index_i <= r.joint; word_index_i <= r.word;
    word_value_i <= r.value;
    pos_x_i <= r.px; pos_y_i <= r.py; pos_z_i <= r.pz;
    nrm_x_i <= r.nx; nrm_y_i <= r.ny; nrm_z_i <= r.nz;
    influence_weight_i <= r.weight; last_influence_i <= r.last;
    in_valid_i <= 1'b1;
    drv_valid = 1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (r.op inside {OP_WORLD, OP_INV_BIND} && r.word < WORDS_PER_JOINT)
      written_mask[r.joint][(r.op == OP_INV_BIND ? 12 : 0) + r.word] = 1'b1;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        drv_valid = 0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_quiet();
    if (drv_valid) begin
      in_valid_i <= 1'b0;
      drv_valid = 0;
    end
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic skin_req_t blank_req();
    skin_req_t r;
    r.op = OP_WORLD; r.joint = '0; r.word = '0; r.value = '0;
    r.px = '0; r.py = '0; r.pz = '0; r.nx = '0; r.ny = '0; r.nz = '0;
    r.weight = '0; r.last = 1'b0;
    return r;
  endfunction

  function automatic int matrix_word();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $urandom_range(0, 262143) - 131072;
  endfunction

  function automatic skin_req_t load_req(logic [1:0] op, int j, int w, int v);
    skin_req_t r;
    r = blank_req();
    r.op = op; r.joint = 6'(j); r.word = 4'(w); r.value = v;
    r.last = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic skin_req_t influence_req(int j, bit last);
    skin_req_t r;
    r = blank_req();
    r.op = OP_INFLUENCE; r.joint = 6'(j); r.last = last;
    r.word = 4'($urandom_range(0, 15)); r.value = $urandom;
    if ($urandom_range(0, 2) == 0) begin
      r.px = $urandom; r.py = $urandom; r.pz = $urandom;
    end else begin
      r.px = $urandom_range(0, 2097151) - 1048576;
      r.py = $urandom_range(0, 2097151) - 1048576;
      r.pz = $urandom_range(0, 2097151) - 1048576;
    end
    r.nx = 18'($urandom_range(0, 262143));
    r.ny = 18'($urandom_range(0, 262143));
    r.nz = 18'($urandom_range(0, 262143));
    r.weight = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(0, 131071))
                                           : 17'($urandom_range(0, 65536));
    return r;
  endfunction

  function automatic int ready_joint();
    int j;
    j = $urandom_range(0, NJOINTS - 1);
    if (&written_mask[j]) return j;
    return $urandom_range(0, 7);
  endfunction

  initial begin
    skin_req_t r;
    int j, sent, nverts;
    foreach (written_mask[i]) written_mask[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // joint 0 identity, joint 1 large words, joints 2..7 and 63 random
    for (int k = 0; k < 12; k++) begin
      send(load_req(OP_WORLD, 0, k, (k == 0 || k == 4 || k == 8) ? 65536 : 0));
      send(load_req(OP_INV_BIND, 0, k, (k == 0 || k == 4 || k == 8) ? 65536 : 0));
      send(load_req(OP_WORLD, 1, k, (k % 2) ? 32'sh7fffffff : 32'sh80000000));
      send(load_req(OP_INV_BIND, 1, k, 32'sh7fffffff));
    end
    for (int jj = 2; jj < 9; jj++)
      for (int k = 0; k < 12; k++) begin
        j = (jj == 8) ? NJOINTS - 1 : jj;
        send(load_req(OP_WORLD, j, k, matrix_word()));
        send(load_req(OP_INV_BIND, j, k, matrix_word()));
      end

    // directed influences: extremes, zero normal, weight edges, ignored items
    r = influence_req(0, 1);
    r.px = 32'sh7fffffff; r.py = 32'sh80000000; r.pz = '0;
    r.nx = 18'sh1ffff; r.ny = 18'sh20000; r.nz = '0; r.weight = 17'd65536;
    send(r);
    r = influence_req(0, 1);
    r.nx = '0; r.ny = '0; r.nz = '0; r.weight = 17'd65536;
    send(r);
    r = influence_req(1, 0); r.weight = 17'h1ffff; send(r);
    r = influence_req(1, 1); r.weight = 17'h1ffff;
    r.px = 32'sh80000000; r.py = 32'sh80000000; r.pz = 32'sh80000000; send(r);
    r = influence_req(2, 1); r.weight = '0; send(r);
    r = influence_req(NJOINTS - 1, 0); send(r);
    send(load_req(OP_UNUSED, 3, 15, $urandom));
    send(load_req(OP_WORLD, 3, 12, $urandom));
    send(load_req(OP_INV_BIND, 3, 15, $urandom));
    r = influence_req(3, 0); send(r);
    r = influence_req(4, 1); send(r);
    r = influence_req(0, 1); r.weight = 17'd32768;
    r.nx = 18'sd1; r.ny = '0; r.nz = '0; send(r);
    wait_quiet();

    // random vertices with loads and noise mixed in
    sent = 0;
    nverts = 0;
    while (sent < RANDOM_ITEMS) begin
      if (nverts == 40) hold_req = 1;
      if (nverts == 300) wait_quiet();
      nverts++;
      while ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 9) == 0)
          send(load_req(2'($urandom_range(0, 3)), $urandom_range(0, 63),
                        $urandom_range(0, 15), $urandom));
        else begin
          send(load_req(2'($urandom_range(0, 1)), $urandom_range(0, 63),
                        $urandom_range(0, 11), matrix_word()));
          sent++;
        end
      end
      j = $urandom_range(1, 4);
      for (int i = 0; i < j; i++) begin
        send(influence_req(ready_joint(), i == j - 1));
        sent++;
      end
    end
    wait_quiet();

    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
